// ----- rtl/eqd_pkg.sv -----
`timescale 1ns / 1ps

package eqd_pkg;

	// Fixed field widths
	localparam int ID_W      = 5;
	localparam int PARAM_W   = 32;
	localparam int MASK_W    = 32;
	localparam int COUNT_W   = 5;
	localparam int ACTION_W  = 3;
	localparam int CFG_IDX_W = 1;
	localparam int ENTRY_W   = ID_W + PARAM_W;

	// Ids at or above this count are never known and always single-instance
	localparam int NUM_IDS = 32;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_POST    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_URGENT  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_GET     = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CLR_ID  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLR_ALL = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ID_KNOWN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MULTI_INST = 1'b1;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     event_id;
		logic [PARAM_W-1:0]  event_param;
	} req_t;

	typedef struct packed {
		logic               accepted;
		logic [ID_W-1:0]    out_id;
		logic [PARAM_W-1:0] out_param;
		logic [COUNT_W-1:0] pending_count;
	} res_t;

endpackage

// ----- rtl/eqd_ram.sv -----
`timescale 1ns / 1ps

module eqd_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 37
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/eqd_ctrl.sv -----
`timescale 1ns / 1ps

module eqd_ctrl #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  eqd_pkg::req_t               req,
	input  logic [eqd_pkg::MASK_W-1:0]  known_mask,
	input  logic [eqd_pkg::MASK_W-1:0]  multi_mask,
	output logic                        idle,
	output logic                        done,
	input  logic                        done_ack,
	output eqd_pkg::res_t               res
);
	import eqd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	// Sequencer states
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DECODE   = 3'd1;
	localparam logic [2:0] ST_SCAN     = 3'd2;
	localparam logic [2:0] ST_SCAN_END = 3'd3;
	localparam logic [2:0] ST_WRITE    = 3'd4;
	localparam logic [2:0] ST_SKIP     = 3'd5;
	localparam logic [2:0] ST_GET_RD   = 3'd6;
	localparam logic [2:0] ST_DONE     = 3'd7;

	logic [2:0]             state_q;
	req_t                   req_q;
	logic [PTR_W-1:0]       head_q;
	logic [PTR_W-1:0]       tail_q;
	logic [CNT_W-1:0]       occ_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [PTR_W-1:0]       scan_q;
	logic                   found_q;
	logic                   rd_pend_s1;
	logic [PTR_W-1:0]       idx_s1;
	logic                   acc_q;
	logic [ID_W-1:0]        rid_q;
	logic [PARAM_W-1:0]     rparam_q;

	logic                   known;
	logic                   multi;
	logic                   full;
	logic                   urgent;
	logic                   skip_now;
	logic                   match;
	logic [PTR_W-1:0]       head_dec;
	logic [PTR_W-1:0]       head_inc;
	logic [PTR_W-1:0]       tail_inc;
	logic                   ram_we;
	logic [PTR_W-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]     ram_wdata;
	logic                   ram_re;
	logic [PTR_W-1:0]       ram_raddr;
	logic [ENTRY_W-1:0]     ram_rdata;
	logic [ID_W-1:0]        rd_id;
	logic [PARAM_W-1:0]     rd_param;

	// Id checks and ring pointer arithmetic
	always_comb begin
		known    = (int'(req_q.event_id) < NUM_IDS) && known_mask[req_q.event_id];
		multi    = (int'(req_q.event_id) < NUM_IDS) && multi_mask[req_q.event_id];
		full     = (occ_q == CNT_FULL);
		urgent   = (req_q.action == ACT_URGENT);
		head_dec = (head_q == '0) ? PTR_LAST : head_q - 1'b1;
		head_inc = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
		tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
		skip_now = (occ_q != '0) && !valid_q[head_q];
	end

	// Slot memory access; each item finishes its writes before the next reads
	assign rd_id     = ram_rdata[ENTRY_W-1 -: ID_W];
	assign rd_param  = ram_rdata[PARAM_W-1:0];
	assign match     = rd_pend_s1 && valid_q[idx_s1] && (rd_id == req_q.event_id);
	assign ram_we    = (state_q == ST_WRITE);
	assign ram_waddr = urgent ? head_dec : tail_q;
	assign ram_wdata = {req_q.event_id, req_q.event_param};
	assign ram_re    = (state_q == ST_SCAN) ||
	                   ((state_q == ST_SKIP) && (occ_q != '0) && valid_q[head_q]);
	assign ram_raddr = (state_q == ST_SCAN) ? scan_q : head_q;

	eqd_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, pointers, count and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			occ_q      <= '0;
			valid_q    <= '0;
			scan_q     <= '0;
			found_q    <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == ST_SCAN);

			// scan compare: dedup hit or clear-by-id invalidate
			if (match) begin
				found_q <= 1'b1;
				if (req_q.action == ACT_CLR_ID) begin
					valid_q[idx_s1] <= 1'b0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					scan_q  <= '0;
					found_q <= 1'b0;
					case (req_q.action)
						ACT_POST: begin
							if (full || !known) begin
								state_q <= ST_DONE;
							end else if (multi) begin
								state_q <= ST_WRITE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						ACT_URGENT: begin
							state_q <= full ? ST_DONE : ST_WRITE;
						end
						ACT_GET: begin
							state_q <= ST_SKIP;
						end
						ACT_CLR_ID: begin
							state_q <= ST_SCAN;
						end
						ACT_CLR_ALL: begin
							head_q  <= '0;
							tail_q  <= '0;
							occ_q   <= '0;
							valid_q <= '0;
							state_q <= ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_SCAN: begin
					if (scan_q == PTR_LAST) begin
						state_q <= ST_SCAN_END;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_SCAN_END: begin
					// last compare lands this cycle
					if ((req_q.action == ACT_POST) && !(found_q || match)) begin
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_WRITE: begin
					valid_q[ram_waddr] <= 1'b1;
					occ_q              <= occ_q + 1'b1;
					if (urgent) begin
						head_q <= head_dec;
					end else begin
						tail_q <= tail_inc;
					end
					state_q <= ST_DONE;
				end
				ST_SKIP: begin
					// drop one invalidated head slot per cycle
					if (skip_now) begin
						head_q <= head_inc;
						occ_q  <= occ_q - 1'b1;
					end else if (occ_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_GET_RD;
					end
				end
				ST_GET_RD: begin
					valid_q[head_q] <= 1'b0;
					head_q          <= head_inc;
					occ_q           <= occ_q - 1'b1;
					state_q         <= ST_DONE;
				end
				ST_DONE: begin
					if (done_ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, scan index pipe and result fields
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			req_q <= req;
		end
		idx_s1 <= scan_q;
		case (state_q)
			ST_DECODE: begin
				acc_q    <= 1'b0;
				rid_q    <= '0;
				rparam_q <= '0;
			end
			ST_WRITE: begin
				acc_q <= 1'b1;
			end
			ST_GET_RD: begin
				acc_q    <= 1'b1;
				rid_q    <= rd_id;
				rparam_q <= rd_param;
			end
			default: begin
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);

	always_comb begin
		res.accepted      = acc_q;
		res.out_id        = rid_q;
		res.out_param     = rparam_q;
		res.pending_count = COUNT_W'(occ_q);
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_FULL)
		else $error("occupancy above queue depth");

	a_empty_no_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (valid_q == '0))
		else $error("valid slot left in an empty queue");

	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> !full)
		else $error("slot write into a full queue");

	a_get_reads_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GET_RD) |-> (valid_q[head_q] && (occ_q != '0)))
		else $error("get pops an invalid head slot");

	a_skip_progress: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SKIP) && skip_now) |=> (occ_q == $past(occ_q) - 1'b1))
		else $error("head skip did not drop the count");

endmodule

// ----- rtl/event_queue_with_dedup_core.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// -------   -------------------------   ---------------------------------------------
// event     evt_valid / evt_stall       action, event_id, event_param
// result    res_valid / res_stall       accepted, out_id, out_param, pending_count
// config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One item at a time through a sequencer around a single-port-read slot RAM.
// Per item: a post refused as full or unknown, an urgent post refused as full, clear all
// and an unused code go from decode to done; an urgent post or a post of a multi-instance
// id that goes in writes one slot; other posts and clear by id scan every slot (one RAM
// read per slot); get drops invalidated head slots, then pops the head if any is left.
// Reset clears pointers, count, valid bits and both masks; slot RAM is not cleared.
// A stalled result sits in the output register while the next item is taken.

module event_queue_with_dedup_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          evt_valid,
	output logic                          evt_stall,
	input  logic [eqd_pkg::ACTION_W-1:0]  action,
	input  logic [eqd_pkg::ID_W-1:0]      event_id,
	input  logic [eqd_pkg::PARAM_W-1:0]   event_param,

	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          accepted,
	output logic [eqd_pkg::ID_W-1:0]      out_id,
	output logic [eqd_pkg::PARAM_W-1:0]   out_param,
	output logic [eqd_pkg::COUNT_W-1:0]   pending_count,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [eqd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [eqd_pkg::MASK_W-1:0]    cfg_data
);
	import eqd_pkg::*;

	logic              ctrl_idle;
	logic              ctrl_done;
	logic              res_ready;
	logic              evt_beat;
	req_t              req;
	res_t              ctrl_res;
	res_t              res_q;
	logic              res_valid_q;
	logic [MASK_W-1:0] known_mask_q;
	logic [MASK_W-1:0] multi_mask_q;

	// Config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_mask_q <= '0;
			multi_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ID_KNOWN:   known_mask_q <= cfg_data;
				REG_MULTI_INST: multi_mask_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Event beat into the sequencer
	assign evt_stall = !ctrl_idle;
	assign evt_beat  = evt_valid && !evt_stall;

	always_comb begin
		req.action      = action;
		req.event_id    = event_id;
		req.event_param = event_param;
	end

	eqd_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (evt_beat),
		.req        (req),
		.known_mask (known_mask_q),
		.multi_mask (multi_mask_q),
		.idle       (ctrl_idle),
		.done       (ctrl_done),
		.done_ack   (res_ready),
		.res        (ctrl_res)
	);

	// Output register
	assign res_ready = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_ready) begin
			res_valid_q <= ctrl_done;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_done && res_ready) begin
			res_q <= ctrl_res;
		end
	end

	assign res_valid     = res_valid_q;
	assign accepted      = res_q.accepted;
	assign out_id        = res_q.out_id;
	assign out_param     = res_q.out_param;
	assign pending_count = res_q.pending_count;

endmodule
